### sv/ef3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ef3_pkg
// Shared constants, types and register map of the 3x3 edge filter.
// ----------------------------------------------------------------------------
package ef3_pkg;

	// storage sizes
	localparam int MAX_WIDTH  = 1024;
	localparam int PIXEL_BITS = 8;

	// widths, some derived from the sizes above
	localparam int COL_BITS    = $clog2(MAX_WIDTH);
	localparam int ROW_BITS    = 12;
	localparam int WIDTH_BITS  = 11;
	localparam int HEIGHT_BITS = 12;
	localparam int MAG_BITS    = PIXEL_BITS + 2;
	localparam int CCOL_BITS   = 10;
	localparam int CROW_BITS   = 12;
	localparam int ADDR_BITS   = 3;
	localparam int DATA_BITS   = 32;
	localparam int MIN_DIM     = 3;

	// register map, indexed by paddr[2]
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

	typedef logic [PIXEL_BITS-1:0]  pixel_t;
	typedef logic [COL_BITS-1:0]    col_t;
	typedef logic [ROW_BITS-1:0]    row_t;
	typedef logic [WIDTH_BITS-1:0]  width_t;
	typedef logic [HEIGHT_BITS-1:0] height_t;
	typedef logic [MAG_BITS-1:0]    mag_t;

	// position of one pixel and what its result will carry
	typedef struct packed {
		col_t col;
		row_t row;
		logic has_result;
		logic last;
	} pos_t;

	// one pixel with its column from the line stores
	typedef struct packed {
		pixel_t pix;
		pixel_t top;
		pixel_t mid;
		pos_t   pos;
	} kern_in_t;

endpackage

### sv/ef3_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ef3_pix_if / ef3_res_if
// Valid/ready channels for the pixel stream and the result stream.
// ----------------------------------------------------------------------------
interface ef3_pix_if;
	import ef3_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t pixel_value;
	logic   start_of_frame;

	modport source (output valid, output pixel_value, output start_of_frame, input ready);
	modport sink (input valid, input pixel_value, input start_of_frame, output ready);
endinterface

interface ef3_res_if;
	import ef3_pkg::*;

	logic                 valid;
	logic                 ready;
	mag_t                 edge_magnitude;
	logic [CCOL_BITS-1:0] center_column;
	logic [CROW_BITS-1:0] center_row;
	logic                 last_of_frame;

	modport source (output valid, output edge_magnitude, output center_column,
		output center_row, output last_of_frame, input ready);
	modport sink (input valid, input edge_magnitude, input center_column,
		input center_row, input last_of_frame, output ready);
endinterface

### sv/edge_filter_3x3_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_filter_3x3_stream
// 3x3 edge filter on a raster-order grey pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the pixels channel (valid/ready), one transfer per pixel,
// start_of_frame marking column 0 of row 0. Each interior pixel gives one
// result transfer on the results channel once the pixel to its lower right
// has arrived: the absolute kernel sum and the pixel's column and row, with
// last_of_frame on the final interior pixel. Border pixels give no result.
// Frame width and height sit in two APB registers at byte addresses 0 and 4;
// write them only while the block is idle.
// Throughput is one pixel per cycle while the receiver takes results. A pixel
// waits in the input stage, where the line store read completes, and its
// result then goes into the result register. The single line store read port
// per row and the one-deep result register set this rate.
// Reset clears the position counters, the window and the pipeline valids;
// the line stores are filled by the first two rows of each frame.
// When the receiver stalls, the result register holds its transfer; the input
// stage still takes a pixel if it is empty, and ready drops while it holds one.
// ----------------------------------------------------------------------------
module edge_filter_3x3_stream (
	input  logic                          clk,
	input  logic                          arst_n,
	ef3_pix_if.sink                       pixels,
	ef3_res_if.source                     results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ef3_pkg::ADDR_BITS-1:0] paddr,
	input  logic [ef3_pkg::DATA_BITS-1:0] pwdata,
	output logic [ef3_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);
	import ef3_pkg::*;

	width_t   eff_width;
	height_t  eff_height;
	pos_t     pos;
	logic     accept;
	logic     advance;
	logic     valid_s1;
	pixel_t   pix_s1;
	pos_t     pos_s1;
	pixel_t   top;
	pixel_t   mid;
	kern_in_t kin;

	ef3_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.eff_width  (eff_width),
		.eff_height (eff_height)
	);

	// handshake: stage 1 moves on when the result register is free or being taken
	assign advance      = valid_s1 && (!results.valid || results.ready);
	assign pixels.ready = !valid_s1 || advance;
	assign accept       = pixels.valid && pixels.ready;

	ef3_position u_position (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.start_of_frame (pixels.start_of_frame),
		.eff_width      (eff_width),
		.eff_height     (eff_height),
		.pos            (pos)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixels.pixel_value;
			pos_s1 <= pos;
		end
	end

	ef3_line_buf u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (pos.col),
		.wr_en   (valid_s1),
		.wr_addr (pos_s1.col),
		.wr_pix  (pix_s1),
		.top     (top),
		.mid     (mid)
	);

	assign kin.pix = pix_s1;
	assign kin.top = top;
	assign kin.mid = mid;
	assign kin.pos = pos_s1;

	ef3_kernel u_kernel (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.kin     (kin),
		.results (results)
	);
endmodule

### sv/ef3_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ef3_cfg
// APB register file for frame size; gives the clamped width and height.
// ----------------------------------------------------------------------------
module ef3_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ef3_pkg::ADDR_BITS-1:0] paddr,
	input  logic [ef3_pkg::DATA_BITS-1:0] pwdata,
	output logic [ef3_pkg::DATA_BITS-1:0] prdata,
	output logic                         pready,
	output ef3_pkg::width_t              eff_width,
	output ef3_pkg::height_t             eff_height
);
	import ef3_pkg::*;

	width_t  frame_width_q;
	height_t frame_height_q;
	logic    wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[WIDTH_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = DATA_BITS'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = DATA_BITS'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// clamp to the supported frame size
	always_comb begin
		if (frame_width_q < WIDTH_BITS'(MIN_DIM))
			eff_width = WIDTH_BITS'(MIN_DIM);
		else if (frame_width_q > WIDTH_BITS'(MAX_WIDTH))
			eff_width = WIDTH_BITS'(MAX_WIDTH);
		else
			eff_width = frame_width_q;
		eff_height = (frame_height_q < HEIGHT_BITS'(MIN_DIM)) ?
			HEIGHT_BITS'(MIN_DIM) : frame_height_q;
	end
endmodule

### sv/ef3_position.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ef3_position
// Column and row counters; tags each pixel with its place in the frame.
// ----------------------------------------------------------------------------
module ef3_position (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             start_of_frame,
	input  ef3_pkg::width_t  eff_width,
	input  ef3_pkg::height_t eff_height,
	output ef3_pkg::pos_t    pos
);
	import ef3_pkg::*;

	col_t                    col_q;
	row_t                    row_q;
	col_t                    c0;
	row_t                    r0;
	logic                    wrap_in;
	logic [ROW_BITS:0]       r1;
	col_t                    c;
	row_t                    r;
	logic [WIDTH_BITS-1:0]   c_next;
	logic [ROW_BITS:0]       r_next;

	// position of the incoming pixel
	always_comb begin
		c0      = start_of_frame ? '0 : col_q;
		r0      = start_of_frame ? '0 : row_q;
		wrap_in = WIDTH_BITS'(c0) >= eff_width;
		c       = wrap_in ? '0 : c0;
		r1      = wrap_in ? ({1'b0, r0} + 1'b1) : {1'b0, r0};
		r       = (r1 >= {1'b0, eff_height}) ? '0 : r1[ROW_BITS-1:0];
		c_next  = WIDTH_BITS'(c) + 1'b1;
		r_next  = {1'b0, r} + 1'b1;

		pos.col        = c;
		pos.row        = r;
		pos.has_result = (c >= COL_BITS'(2)) && (r >= ROW_BITS'(2));
		pos.last       = (WIDTH_BITS'(c) == eff_width - 1'b1) &&
			(r == eff_height - 1'b1);
	end

	// advance past the accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c_next >= eff_width) begin
				col_q <= '0;
				row_q <= (r_next >= {1'b0, eff_height}) ? '0 : r_next[ROW_BITS-1:0];
			end else begin
				col_q <= c_next[COL_BITS-1:0];
				row_q <= r;
			end
		end
	end
endmodule

### sv/ef3_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ef3_line_buf
// Two line stores; read on accept, shifted down one row from stage 1.
// ----------------------------------------------------------------------------
module ef3_line_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  ef3_pkg::col_t    rd_addr,
	input  logic             wr_en,
	input  ef3_pkg::col_t    wr_addr,
	input  ef3_pkg::pixel_t  wr_pix,
	output ef3_pkg::pixel_t  top,
	output ef3_pkg::pixel_t  mid
);
	import ef3_pkg::*;

	pixel_t upper_mem [MAX_WIDTH];
	pixel_t middle_mem [MAX_WIDTH];
	pixel_t rd_upper_s1;
	pixel_t rd_mid_s1;
	pixel_t fwd_top_s1;
	pixel_t fwd_mid_s1;
	logic   fwd_s1;

	// column seen by the pixel in stage 1
	assign top = fwd_s1 ? fwd_top_s1 : rd_upper_s1;
	assign mid = fwd_s1 ? fwd_mid_s1 : rd_mid_s1;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr]  <= mid;
			middle_mem[wr_addr] <= wr_pix;
		end
		if (rd_en) begin
			rd_upper_s1 <= upper_mem[rd_addr];
			rd_mid_s1   <= middle_mem[rd_addr];
			fwd_top_s1  <= mid;
			fwd_mid_s1  <= wr_pix;
		end
	end

	// bypass when the write at the same column lands on the read edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else if (rd_en) begin
			fwd_s1 <= wr_en && (wr_addr == rd_addr);
		end
	end
endmodule

### sv/ef3_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ef3_kernel
// 3x3 window, kernel sum with absolute value, and the result register.
// ----------------------------------------------------------------------------
module ef3_kernel (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  ef3_pkg::kern_in_t  kin,
	ef3_res_if.source          results
);
	import ef3_pkg::*;

	pixel_t win_q [6];
	mag_t   sum_pos;
	mag_t   sum_neg;
	mag_t   mag;
	logic   valid_s2;
	mag_t   mag_s2;
	col_t   col_s2;
	row_t   row_s2;
	logic   last_s2;

	// right column plus below, minus left column plus above
	always_comb begin
		sum_pos = MAG_BITS'(kin.top) + MAG_BITS'(kin.mid) + MAG_BITS'(kin.pix) +
			MAG_BITS'(win_q[5]);
		sum_neg = MAG_BITS'(win_q[0]) + MAG_BITS'(win_q[1]) + MAG_BITS'(win_q[2]) +
			MAG_BITS'(win_q[3]);
		mag     = (sum_pos >= sum_neg) ? (sum_pos - sum_neg) : (sum_neg - sum_pos);
	end

	// window shifts once per pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (advance) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= kin.top;
			win_q[4] <= kin.mid;
			win_q[5] <= kin.pix;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= kin.pos.has_result;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && kin.pos.has_result) begin
			mag_s2  <= mag;
			col_s2  <= kin.pos.col - 1'b1;
			row_s2  <= kin.pos.row - 1'b1;
			last_s2 <= kin.pos.last;
		end
	end

	assign results.valid          = valid_s2;
	assign results.edge_magnitude = mag_s2;
	assign results.center_column  = CCOL_BITS'(col_s2);
	assign results.center_row     = CROW_BITS'(row_s2);
	assign results.last_of_frame  = last_s2;
endmodule

### sv/ef3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ef3_checker
// Port-level checks of the edge filter, bound to the top level.
// ----------------------------------------------------------------------------
module ef3_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [ef3_pkg::MAG_BITS-1:0]  out_mag,
	input logic [ef3_pkg::CCOL_BITS-1:0] out_col,
	input logic [ef3_pkg::CROW_BITS-1:0] out_row
);
	import ef3_pkg::*;

	// a result waiting for the receiver stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_mag) && $stable(out_col) && $stable(out_row))
		else $error("result changed while stalled");

	// input is only held off while the result side is blocked
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled with free result register");

	// results never lie on the top row or the left column
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_col != '0) && (out_row != '0))
		else $error("result on a border pixel");
endmodule

bind edge_filter_3x3_stream ef3_checker u_ef3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_mag   (results.edge_magnitude),
	.out_col   (results.center_column),
	.out_row   (results.center_row)
);
